[rtl/assert_macros.svh]
// Assertion macros for the checker file of the blur block.
// Needs a clk in the scope of each use, and an active-low rst_n for GB7_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define GB7_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define GB7_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gb7_pkg.sv]
// Shared constants, kernel weights and types of the 7x7 Gaussian blur.
// No dependencies; the front, back, top level and checker files import it.
`timescale 1ns / 1ps
`default_nettype none
package gb7_pkg;
  localparam int TAPS               = 7;
  localparam int HALF               = 3;
  localparam int SIZE_MIN           = 4;
  localparam int SIZE_RESET         = 256;
  localparam int MAX_IMAGE_SIZE_DEF = 1024;
  localparam int CFG_W              = 11;
  localparam int PIX_W              = 8;
  localparam int W_W                = 14;
  localparam int SLOT_W             = 3;
  localparam int V_W                = 23;   // one column sum: 255 * 32768 < 2^23
  localparam int P_W                = V_W + W_W;
  localparam int ACC_W              = 38;   // 255 * 2^30 < 2^38
  localparam int SHIFT              = 30;

  // Q1.15 taps of the sigma 1 kernel, sum 32768
  localparam logic [W_W-1:0] GAUSS_W [TAPS] = '{
    14'd145, 14'd1770, 14'd7930, 14'd13078, 14'd7930, 14'd1770, 14'd145
  };

  // Per column job: line slot for each kernel row, and row position flags
  typedef struct packed {
    logic                          last_col;
    logic                          frame_row;
    logic [TAPS-1:0][SLOT_W-1:0]   sel;
  } job_ctl_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic last;
  } out_flags_t;
endpackage
`default_nettype wire

[rtl/gb7_fifo.sv]
// Two-entry job queue between the front and back parts of the blur.
// Generic payload width; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module gb7_fifo #(
  parameter int DATA_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  output logic                   valid,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      data
);
  logic [DATA_W-1:0] mem_r [2];
  logic              wptr_r, wptr_nxt;
  logic              rptr_r, rptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

[rtl/gb7_front.sv]
// Front part of the blur: size register, frame counters, line store writes,
// and per-column jobs with mirrored line slots. Depends on gb7_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gb7_front import gb7_pkg::*; #(
  parameter int  MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF,
  localparam int COL_W = $clog2(MAX_IMAGE_SIZE)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_action,
  input  wire logic [PIX_W-1:0] in_pixel,
  input  wire logic             q_full,
  input  wire logic             q_valid,
  output logic                  push,
  output logic [COL_W-1:0]      push_col,
  output job_ctl_t              push_ctl,
  output logic                  wr_en,
  output logic [SLOT_W-1:0]     wr_slot,
  output logic [COL_W-1:0]      wr_col,
  output logic [PIX_W-1:0]      wr_data
);
  localparam int SIZE_W = $clog2(MAX_IMAGE_SIZE + 1);
  localparam int ROW_W  = $clog2(MAX_IMAGE_SIZE + HALF + 1);
  localparam int CMP_W  = ((CFG_W > SIZE_W) ? CFG_W : SIZE_W) + 1;

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;

  logic              take, live, last_col, frame_row, top, bottom;
  logic [ROW_W-1:0]  size_x, col_x, orow, bot_d;
  logic [CMP_W-1:0]  cfg_x;
  logic [SLOT_W-1:0] oslot;

  // hold the first rows of a frame until queued jobs of the last frame have read the store
  assign in_ready  = !q_full && !(q_valid && (row_r < ROW_W'(HALF)));
  assign take      = in_valid && in_ready;
  assign size_x    = ROW_W'(size_r);
  assign col_x     = ROW_W'(col_r);
  assign live      = in_action ? (row_r >= size_x) : (row_r < size_x);
  assign last_col  = (ROW_W'(col_x + ROW_W'(1)) == size_x);
  assign frame_row = (row_r == ROW_W'(size_x + ROW_W'(2)));
  assign orow      = ROW_W'(row_r - ROW_W'(HALF));
  assign bot_d     = ROW_W'(size_x + ROW_W'(2) - row_r);
  assign top       = (row_r < ROW_W'(2 * HALF));
  assign bottom    = (bot_d < ROW_W'(HALF));
  assign cfg_x     = CMP_W'(cfg_wr_data);
  // line r-3 sits in slot (r + 4) mod 7
  assign oslot     = (rslot_r >= SLOT_W'(HALF)) ? SLOT_W'(rslot_r - SLOT_W'(HALF))
                                                : SLOT_W'(rslot_r + SLOT_W'(HALF + 1));

  // store the pixel of a live image item
  assign wr_en   = take && live && !in_action;
  assign wr_slot = rslot_r;
  assign wr_col  = col_r;
  assign wr_data = in_pixel;

  // a column job once three rows are in
  assign push     = take && live && (row_r >= ROW_W'(HALF));
  assign push_col = col_r;

  always_comb begin
    logic signed [4:0] e, delta, ssum, orow_s, bot_s, oslot_s;
    orow_s  = $signed({3'b000, orow[1:0]});
    bot_s   = $signed({3'b000, bot_d[1:0]});
    oslot_s = $signed({2'b00, oslot});
    push_ctl.last_col  = last_col;
    push_ctl.frame_row = frame_row;
    for (int dy = 0; dy < TAPS; dy++) begin
      e = 5'(dy - HALF);
      // mirror above the top line and below the bottom line, edge not repeated
      if (top && (orow_s + e < 5'sd0)) begin
        delta = 5'sd0 - orow_s - orow_s - e;
      end else if (bottom && (e > bot_s)) begin
        delta = bot_s + bot_s - e;
      end else begin
        delta = e;
      end
      ssum = oslot_s + delta;
      if (ssum < 5'sd0) begin
        ssum = ssum + 5'sd7;
      end else if (ssum >= 5'sd7) begin
        ssum = ssum - 5'sd7;
      end
      push_ctl.sel[dy] = ssum[SLOT_W-1:0];
    end
  end

  always_comb begin
    size_nxt  = size_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    rslot_nxt = rslot_r;
    if (cfg_wr_en) begin
      if (cfg_x < CMP_W'(SIZE_MIN)) begin
        size_nxt = SIZE_W'(SIZE_MIN);
      end else if (cfg_x > CMP_W'(MAX_IMAGE_SIZE)) begin
        size_nxt = SIZE_W'(MAX_IMAGE_SIZE);
      end else begin
        size_nxt = SIZE_W'(cfg_x);
      end
      row_nxt   = '0;
      col_nxt   = '0;
      rslot_nxt = '0;
    end else if (take && live) begin
      if (last_col) begin
        col_nxt   = '0;
        row_nxt   = ROW_W'(row_r + ROW_W'(1));
        rslot_nxt = (rslot_r == SLOT_W'(TAPS - 1)) ? '0 : SLOT_W'(rslot_r + SLOT_W'(1));
        if (frame_row) begin
          row_nxt   = '0;
          rslot_nxt = '0;
        end
      end else begin
        col_nxt = COL_W'(col_r + COL_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_W'(SIZE_RESET);
      row_r   <= '0;
      col_r   <= '0;
      rslot_r <= '0;
    end else begin
      size_r  <= size_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      rslot_r <= rslot_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/gb7_back.sv]
// Back part of the blur: seven line banks, column sums, horizontal window
// with edge mirroring, and the output register. Depends on gb7_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gb7_back import gb7_pkg::*; #(
  parameter int  MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF,
  localparam int COL_W = $clog2(MAX_IMAGE_SIZE)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_slot,
  input  wire logic [COL_W-1:0]  wr_col,
  input  wire logic [PIX_W-1:0]  wr_data,
  input  wire logic              q_valid,
  input  wire logic [COL_W-1:0]  q_col,
  input  wire job_ctl_t          q_ctl,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       out_smoothed,
  output logic                   out_row_end,
  output logic                   out_frame_end,
  output logic                   out_last
);
  logic [PIX_W-1:0] rd_r [TAPS];

  logic             s1_v_r, s1_v_nxt;
  logic [COL_W-1:0] s1_col_r;
  job_ctl_t         s1_ctl_r;

  logic [V_W-1:0]   sr_r [TAPS];
  logic             s2_v_r, s2_v_nxt;
  logic [COL_W-1:0] s2_col_r;
  logic             s2_last_col_r, s2_frame_row_r;
  logic [1:0]       cnt_r, cnt_nxt;

  logic [P_W-1:0]   s3_p_r [TAPS];
  logic             s3_v_r;
  out_flags_t       s3_fl_r, emit_fl, out_fl_r;
  logic             out_v_r;
  logic [PIX_W-1:0] out_pix_r;

  logic             adv, has_out, last_emit, emit, s2_free, s1_move, lo_col;
  logic [V_W-1:0]   vsum;
  logic [ACC_W-1:0] hsum;
  logic [3:0]       pos [TAPS];

  generate
    for (genvar b = 0; b < TAPS; b++) begin : g_bank
      logic [PIX_W-1:0] bank_r [MAX_IMAGE_SIZE];
      always_ff @(posedge clk) begin
        if (wr_en && (wr_slot == SLOT_W'(b))) begin
          bank_r[wr_col] <= wr_data;
        end
      end
      always_ff @(posedge clk) begin
        if (q_pop) begin
          rd_r[b] <= bank_r[q_col];
        end
      end
    end
  endgenerate

  // stall everything behind a held result
  assign adv       = !out_v_r || out_ready;
  assign has_out   = (s2_col_r >= COL_W'(HALF));
  assign last_emit = !s2_last_col_r || (cnt_r == 2'd3);
  assign emit      = s2_v_r && has_out && adv;
  assign s2_free   = !s2_v_r || !has_out || (adv && last_emit);
  assign s1_move   = s1_v_r && s2_free;
  assign q_pop     = q_valid && (!s1_v_r || s2_free);
  assign lo_col    = (s2_col_r < COL_W'(2 * HALF));

  always_comb begin
    s1_v_nxt = q_pop ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
    s2_v_nxt = s1_move ? 1'b1 : (s2_free ? 1'b0 : s2_v_r);
    cnt_nxt  = s1_move ? 2'd0 : (emit ? 2'(cnt_r + 2'd1) : cnt_r);
  end

  // vertical sum of one column over the mirrored lines
  always_comb begin
    vsum = '0;
    for (int dy = 0; dy < TAPS; dy++) begin
      vsum = V_W'(vsum + V_W'(rd_r[s1_ctl_r.sel[dy]]) * V_W'(GAUSS_W[dy]));
    end
  end

  // window position of each tap; sr_r[0] holds the newest column
  always_comb begin
    logic [3:0] cl, base;
    cl   = {1'b0, s2_col_r[2:0]};
    base = 4'(cnt_r);
    for (int d = 0; d < TAPS; d++) begin
      if (lo_col && (4'(cl + base + 4'(d)) < 4'(2 * HALF))) begin
        pos[d] = 4'(cl + cl + base + 4'(d) - 4'(2 * HALF));
      end else if (s2_last_col_r && (4'(base + 4'(d)) > 4'(2 * HALF))) begin
        pos[d] = 4'(base + 4'(d) - 4'(2 * HALF));
      end else begin
        pos[d] = 4'(4'(2 * HALF) - base - 4'(d));
      end
    end
  end

  always_comb begin
    emit_fl.row_end   = s2_last_col_r && (cnt_r == 2'd3);
    emit_fl.frame_end = s2_last_col_r && (cnt_r == 2'd3) && s2_frame_row_r;
    emit_fl.last      = last_emit;
  end

  always_comb begin
    hsum = '0;
    for (int d = 0; d < TAPS; d++) begin
      hsum = ACC_W'(hsum + ACC_W'(s3_p_r[d]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      cnt_r   <= 2'd0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      cnt_r  <= cnt_nxt;
      if (adv) begin
        s3_v_r  <= emit;
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_col_r <= q_col;
      s1_ctl_r <= q_ctl;
    end
    if (s1_move) begin
      sr_r[0] <= vsum;
      for (int i = 1; i < TAPS; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
      s2_col_r       <= s1_col_r;
      s2_last_col_r  <= s1_ctl_r.last_col;
      s2_frame_row_r <= s1_ctl_r.frame_row;
    end
    if (adv) begin
      for (int d = 0; d < TAPS; d++) begin
        s3_p_r[d] <= P_W'(sr_r[pos[d][2:0]]) * P_W'(GAUSS_W[d]);
      end
      s3_fl_r   <= emit_fl;
      out_pix_r <= hsum[SHIFT +: PIX_W];
      out_fl_r  <= s3_fl_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_smoothed  = out_pix_r;
  assign out_row_end   = out_fl_r.row_end;
  assign out_frame_end = out_fl_r.frame_end;
  assign out_last      = out_fl_r.last;
endmodule
`default_nettype wire

[rtl/gaussian_blur_7x7.sv]
// Top level of the streaming 7x7 Gaussian blur (sigma 1) for square grey frames.
// Instantiates gb7_front, gb7_fifo and gb7_back; uses gb7_pkg.
//
// Feed the frame's pixels in raster order with in_action low, then 3*S items
// with in_action high to flush the last three output rows; output runs three
// rows behind the input. Each result is the separable Q1.15 kernel
// 145,1770,7930,13078,7930,1770,145 applied in both directions, shifted right
// by 30. Borders mirror without repeating the edge pixel. The block takes one
// item per clock while in_ready is high; the back end emits nothing for the
// first three columns of an output row, one result for each later column and
// four on its last column, and the two-entry job queue lets the front keep
// taking items while the back end is busy. The first three rows of a frame
// also wait until every job still queued from the previous frame has read
// the line store, so new lines never overwrite lines still needed. Write
// cfg_wr_data (clamped to 4..MAX_IMAGE_SIZE) only while idle; each write
// restarts the frame.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_blur_7x7 import gb7_pkg::*; #(
  parameter int MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_action,
  input  wire logic [PIX_W-1:0] in_pixel,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PIX_W-1:0]      out_smoothed,
  output logic                  out_row_end,
  output logic                  out_frame_end,
  output logic                  out_last
);
  localparam int COL_W  = $clog2(MAX_IMAGE_SIZE);
  localparam int JOB_W  = $bits(job_ctl_t) + COL_W;

  // front to queue
  logic              push;
  logic [COL_W-1:0]  push_col;
  job_ctl_t          push_ctl;
  logic              q_full;
  // front to line banks
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [COL_W-1:0]  wr_col;
  logic [PIX_W-1:0]  wr_data;
  // queue to back
  logic              q_valid, q_pop;
  logic [JOB_W-1:0]  q_data;
  logic [COL_W-1:0]  q_col;
  job_ctl_t          q_ctl;

  assign q_col = q_data[JOB_W-1 -: COL_W];
  assign q_ctl = job_ctl_t'(q_data[$bits(job_ctl_t)-1:0]);

  // count, store and classify each item
  gb7_front #(
    .MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_pixel   (in_pixel),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .push       (push),
    .push_col   (push_col),
    .push_ctl   (push_ctl),
    .wr_en      (wr_en),
    .wr_slot    (wr_slot),
    .wr_col     (wr_col),
    .wr_data    (wr_data)
  );

  // hold up to two column jobs so each side can stall alone
  gb7_fifo #(
    .DATA_W(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_col, push_ctl}),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .data     (q_data)
  );

  // read the column, filter, and present results
  gb7_back #(
    .MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (wr_en),
    .wr_slot      (wr_slot),
    .wr_col       (wr_col),
    .wr_data      (wr_data),
    .q_valid      (q_valid),
    .q_col        (q_col),
    .q_ctl        (q_ctl),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_smoothed (out_smoothed),
    .out_row_end  (out_row_end),
    .out_frame_end(out_frame_end),
    .out_last     (out_last)
  );
endmodule
`default_nettype wire

[rtl/gb7_checker.sv]
// Port-level checks of the blur's result stream, bound to the top level.
// Depends on assert_macros.svh and gb7_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gb7_checker import gb7_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIX_W-1:0] out_smoothed,
  input wire logic             out_row_end,
  input wire logic             out_frame_end,
  input wire logic             out_last
);
  `GB7_ASSERT(a_frame_in_row, out_valid && out_frame_end |-> out_row_end, "frame end off row end")
  `GB7_ASSERT(a_row_is_last, out_valid && out_row_end |-> out_last, "row end not last of item")
  `GB7_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_smoothed), "result dropped")
  `GB7_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result right after reset")
endmodule

bind gaussian_blur_7x7 gb7_checker u_gb7_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_smoothed (out_smoothed),
  .out_row_end  (out_row_end),
  .out_frame_end(out_frame_end),
  .out_last     (out_last)
);
`default_nettype wire
